// ===== src/irad_pkg.sv =====
// Shared types and constants for the integer radical block.
// No dependencies; imported by irad_alu and integer_radical.
package irad_pkg;

  // Default width of the operand and result
  localparam int IRAD_VALUE_BITS = 31;

  // Operations of the shared shift/add unit
  typedef enum logic {
    IRAD_OP_DIV = 1'b0,
    IRAD_OP_MUL = 1'b1
  } irad_op_t;

  // Launch request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic     start;
    irad_op_t op;
  } irad_req_t;

endpackage

// ===== src/integer_radical.sv =====
// Integer radical, top level: trial-division sequencer around irad_alu.
// Depends on irad_pkg and irad_alu.
//
// Returns the product of the distinct prime factors of in_n_value (1 for 0 and 1).
// A request is taken when start is high and busy is low; busy drops in the cycle
// the result is presented, so the next request can be taken at the edge that ends
// it. The result appears on out_radical for exactly one cycle with out_valid high
// and cannot be stalled. Every step runs on one shared bit-serial divide/multiply
// unit, so divisions and multiplications run one after another. A request
// performs D + M operations on that unit, where D is the number of trial and
// divide-out divisions (roughly one per candidate up to the square root of the
// shrinking remainder) and M the number of distinct primes.
// A prime near 2^31 needs about 46k divisions.
module integer_radical #(
  parameter int VALUE_BITS = irad_pkg::IRAD_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_n_value,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_radical
);
  import irad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;       // remaining value
  logic [VALUE_BITS-1:0] d_r, d_nxt;       // candidate divisor
  logic [VALUE_BITS-1:0] prod_r, prod_nxt; // running product
  logic                  divout_r, divout_nxt; // dividing out a found factor
  logic                  final_r, final_nxt;   // last multiply by leftover prime
  logic                  start_r, start_nxt;
  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] rad_r, rad_nxt;

  irad_req_t             alu_req;
  logic                  alu_done;
  logic [VALUE_BITS-1:0] alu_main, alu_rem;

  // Launch request and operands for the shared unit
  always_comb begin
    alu_req.start = start_r;
    alu_req.op    = (state_r == S_MUL) ? IRAD_OP_MUL : IRAD_OP_DIV;
  end

  irad_alu #(
    .VALUE_BITS(VALUE_BITS)
  ) u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (alu_req),
    .opa      ((state_r == S_MUL) ? prod_r : v_r),
    .opb      ((state_r == S_MUL) ? (final_r ? v_r : d_r) : d_r),
    .done     (alu_done),
    .res_main (alu_main),
    .res_rem  (alu_rem)
  );

  // Trial-division sequencer
  always_comb begin
    state_nxt  = state_r;
    v_nxt      = v_r;
    d_nxt      = d_r;
    prod_nxt   = prod_r;
    divout_nxt = divout_r;
    final_nxt  = final_r;
    start_nxt  = 1'b0;
    valid_nxt  = 1'b0;
    rad_nxt    = rad_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt      = in_n_value;
          d_nxt      = VALUE_BITS'(2);
          prod_nxt   = VALUE_BITS'(1);
          divout_nxt = 1'b0;
          final_nxt  = 1'b0;
          start_nxt  = 1'b1;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (alu_done) begin
          if (divout_r) begin
            // Keep dividing the factor out, then move to the next candidate
            if (alu_rem == '0) begin
              v_nxt = alu_main;
            end else begin
              d_nxt      = d_r + 1'b1;
              divout_nxt = 1'b0;
            end
            start_nxt = 1'b1;
          end else if (d_r > alu_main) begin
            // Candidate passed the square root: leftover is 1 or a prime
            final_nxt = 1'b1;
            if (v_r > VALUE_BITS'(1)) begin
              state_nxt = S_MUL;
              start_nxt = 1'b1;
            end else begin
              rad_nxt   = prod_r;
              valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (alu_rem == '0) begin
            // New prime factor: take it once into the product
            v_nxt     = alu_main;
            state_nxt = S_MUL;
            start_nxt = 1'b1;
          end else begin
            d_nxt     = d_r + 1'b1;
            start_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (alu_done) begin
          prod_nxt = alu_main;
          if (final_r) begin
            rad_nxt   = alu_main;
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            divout_nxt = 1'b1;
            start_nxt  = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= 1'b0;
      valid_r  <= 1'b0;
      divout_r <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      valid_r  <= valid_nxt;
      divout_r <= divout_nxt;
      final_r  <= final_nxt;
    end
    v_r    <= v_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    rad_r  <= rad_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = valid_r;
  assign out_radical = rad_r;

`ifndef SYNTH
  // Result strobe lasts a single cycle
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // Unit completions only arrive while a computation is running
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == S_DIV || state_r == S_MUL))
    else $error("arithmetic unit finished while sequencer idle");

  // A radical is never zero
  a_rad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_radical != '0))
    else $error("zero radical returned");

  // A launch never coincides with a completion of the shared unit
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !alu_done)
    else $error("shared unit relaunched during completion");
`endif

endmodule

// ===== src/irad_alu.sv =====
// Shared bit-serial arithmetic unit: restoring divide or shift-add multiply.
// Depends on irad_pkg (irad_req_t, irad_op_t).
module irad_alu #(
  parameter int VALUE_BITS = irad_pkg::IRAD_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  irad_pkg::irad_req_t   req,
  input  logic [VALUE_BITS-1:0] opa,      // dividend or multiplicand
  input  logic [VALUE_BITS-1:0] opb,      // divisor or multiplier
  output logic                  done,     // one-cycle pulse, results valid
  output logic [VALUE_BITS-1:0] res_main, // quotient or product
  output logic [VALUE_BITS-1:0] res_rem   // remainder
);
  import irad_pkg::*;

  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] shf_r, shf_nxt;
  logic [VALUE_BITS-1:0] opnd_r, opnd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  irad_op_t              op_r, op_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // One adder/subtractor shared by both operations
  logic [VALUE_BITS:0] x_op, y_op, sum;
  logic                qbit;

  always_comb begin
    x_op = {acc_r, (op_r == IRAD_OP_DIV) ? shf_r[VALUE_BITS-1] : 1'b0};
    if (op_r == IRAD_OP_DIV) begin
      y_op = {1'b0, opnd_r};
      sum  = x_op - y_op;
    end else begin
      y_op = shf_r[VALUE_BITS-1] ? {1'b0, opnd_r} : '0;
      sum  = x_op + y_op;
    end
    // Trial subtract succeeds when no borrow
    qbit = ~sum[VALUE_BITS];
  end

  // Step control
  always_comb begin
    acc_nxt  = acc_r;
    shf_nxt  = shf_r;
    opnd_nxt = opnd_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      op_nxt   = req.op;
      shf_nxt  = (req.op == IRAD_OP_DIV) ? opa : opb;
      opnd_nxt = (req.op == IRAD_OP_DIV) ? opb : opa;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (op_r == IRAD_OP_DIV) begin
        // partial remainder stays below the divisor, so it fits the field
        acc_nxt = qbit ? sum[VALUE_BITS-1:0] : x_op[VALUE_BITS-1:0];
        shf_nxt = {shf_r[VALUE_BITS-2:0], qbit};
      end else begin
        acc_nxt = sum[VALUE_BITS-1:0];
        shf_nxt = {shf_r[VALUE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= IRAD_OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    shf_r  <= shf_nxt;
    opnd_r <= opnd_nxt;
  end

  assign done     = done_r;
  assign res_main = (op_r == IRAD_OP_DIV) ? shf_r : acc_r;
  assign res_rem  = acc_r;

endmodule
